/* rtl/trq_pkg.sv */
// ----------------------------------------------------------------------------
// trq_pkg
// Shared types and constants for the touch report qualifier.
// ----------------------------------------------------------------------------
package trq_pkg;

    localparam int COORD_W    = 12;
    localparam int SCREEN_W   = 13;
    localparam int HOLD_W     = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COORD_W-1:0]    MARKER_COORD   = 12'd273;
    localparam logic [3:0]            NIBBLE_MASK    = 4'hF;
    localparam logic [HOLD_W-1:0]     HOLD_MS_RST    = 16'd60;
    localparam logic [SCREEN_W-1:0]   SCREEN_W_RST   = 13'd320;
    localparam logic [SCREEN_W-1:0]   SCREEN_H_RST   = 13'd480;

    localparam logic [CFG_IDX_W-1:0]  CFG_HOLD_MS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0]  CFG_SCREEN_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        CLASS_VALID  = 2'd0,
        CLASS_NONE   = 2'd1,
        CLASS_GLITCH = 2'd2
    } report_class_t;

    typedef struct packed {
        logic              read_ok;
        logic [7:0]        finger_count;
        logic [7:0]        x_high_byte;
        logic [7:0]        x_low_byte;
        logic [7:0]        y_high_byte;
        logic [7:0]        y_low_byte;
        logic [TIME_W-1:0] now_ms;
    } in_t;

    typedef struct packed {
        logic               touched;
        logic [COORD_W-1:0] touch_x;
        logic [COORD_W-1:0] touch_y;
        report_class_t      report_class;
    } out_t;

    typedef struct packed {
        logic [SCREEN_W-1:0] screen_width;
        logic [SCREEN_W-1:0] screen_height;
    } screen_cfg_t;

    typedef struct packed {
        report_class_t      report_class;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } class_res_t;

endpackage

/* rtl/trq_classify.sv */
// ----------------------------------------------------------------------------
// trq_classify
// Decodes one report into a coordinate and sorts it into valid, no finger
// or glitch.
// ----------------------------------------------------------------------------
module trq_classify
(
    input  trq_pkg::in_t         report,
    input  trq_pkg::screen_cfg_t screen,
    output trq_pkg::class_res_t  result
);

    logic [trq_pkg::COORD_W-1:0] x;
    logic [trq_pkg::COORD_W-1:0] y;
    logic                        is_marker;
    logic                        off_screen;

    assign x = {report.x_high_byte[3:0] & trq_pkg::NIBBLE_MASK, report.x_low_byte};
    assign y = {report.y_high_byte[3:0] & trq_pkg::NIBBLE_MASK, report.y_low_byte};

    assign is_marker  = (x == trq_pkg::MARKER_COORD) && (y == trq_pkg::MARKER_COORD);
    assign off_screen = ({1'b0, x} >= screen.screen_width)
                     || ({1'b0, y} >= screen.screen_height);

    always_comb
    begin
        result.x = x;
        result.y = y;
        if (!report.read_ok)
        begin
            result.report_class = trq_pkg::CLASS_GLITCH;
        end
        else if (report.finger_count == 8'd0)
        begin
            result.report_class = trq_pkg::CLASS_NONE;
        end
        else if (report.finger_count != 8'd1 || is_marker || off_screen)
        begin
            result.report_class = trq_pkg::CLASS_GLITCH;
        end
        else
        begin
            result.report_class = trq_pkg::CLASS_VALID;
        end
    end

endmodule

/* rtl/touch_report_qualifier_top.sv */
// ----------------------------------------------------------------------------
// touch_report_qualifier_top
// Qualifies polled touch reports: glitch filter with release hold.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_data  (trq_pkg::in_t)
//   out     | output    | out_valid / out_stall| out_data (trq_pkg::out_t)
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; each request passes
// the input register, then classify and state update into the result register.
// Touch state updates as a request moves from the input to the result register.
// Reset clears state to released, coordinates and time zero, registers default.
// in_stall rises only while both registers are full and out_stall is high.
// cfg_ready is always high; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module touch_report_qualifier_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  trq_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output trq_pkg::out_t                  out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [trq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trq_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [trq_pkg::HOLD_W-1:0]   hold_ms_reg;
    trq_pkg::screen_cfg_t         screen_reg;

    logic                         s1_valid_reg;
    trq_pkg::in_t                 s1_data_reg;
    logic                         out_valid_reg;
    trq_pkg::out_t                out_data_reg;
    trq_pkg::out_t                out_data_next;

    logic [trq_pkg::COORD_W-1:0]  held_x_reg;
    logic [trq_pkg::COORD_W-1:0]  held_y_reg;
    logic [trq_pkg::TIME_W-1:0]   last_time_reg;
    logic                         pressed_reg;
    logic [trq_pkg::COORD_W-1:0]  held_x_next;
    logic [trq_pkg::COORD_W-1:0]  held_y_next;
    logic [trq_pkg::TIME_W-1:0]   last_time_next;
    logic                         pressed_next;

    trq_pkg::class_res_t          cls;
    logic [trq_pkg::TIME_W-1:0]   elapsed;
    logic                         out_load;
    logic                         s1_adv;
    logic                         in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg              <= trq_pkg::HOLD_MS_RST;
            screen_reg.screen_width  <= trq_pkg::SCREEN_W_RST;
            screen_reg.screen_height <= trq_pkg::SCREEN_H_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                trq_pkg::CFG_HOLD_MS:       hold_ms_reg <= cfg_data;
                trq_pkg::CFG_SCREEN_WIDTH:  screen_reg.screen_width <=
                                                cfg_data[trq_pkg::SCREEN_W-1:0];
                trq_pkg::CFG_SCREEN_HEIGHT: screen_reg.screen_height <=
                                                cfg_data[trq_pkg::SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    trq_classify u_classify
    (
        .report (s1_data_reg),
        .screen (screen_reg),
        .result (cls)
    );

    assign out_load = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;
    assign elapsed  = s1_data_reg.now_ms - last_time_reg;

    always_comb
    begin
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        last_time_next = last_time_reg;
        pressed_next   = pressed_reg;
        case (cls.report_class)
            trq_pkg::CLASS_VALID:
            begin
                held_x_next    = cls.x;
                held_y_next    = cls.y;
                last_time_next = s1_data_reg.now_ms;
                pressed_next   = 1'b1;
            end
            trq_pkg::CLASS_NONE:
            begin
                pressed_next = 1'b0;
            end
            default:
            begin
                if (pressed_reg && (elapsed > {16'd0, hold_ms_reg}))
                begin
                    pressed_next = 1'b0;
                end
            end
        endcase
        out_data_next.touched      = pressed_next;
        out_data_next.touch_x      = pressed_next ? held_x_next : '0;
        out_data_next.touch_y      = pressed_next ? held_y_next : '0;
        out_data_next.report_class = cls.report_class;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            last_time_reg <= '0;
            pressed_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                held_x_reg    <= held_x_next;
                held_y_reg    <= held_y_next;
                last_time_reg <= last_time_next;
                pressed_reg   <= pressed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_released_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.touched |-> out_data.touch_x == '0 && out_data.touch_y == '0)
        else $error("released result carries a coordinate");

    a_valid_presses: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && cls.report_class == trq_pkg::CLASS_VALID |=> pressed_reg)
        else $error("valid report did not press");

    a_none_releases: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && cls.report_class == trq_pkg::CLASS_NONE |=> !pressed_reg)
        else $error("no-finger report did not release");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_data.touched == pressed_reg)
        else $error("result touched differs from state");

endmodule
